FILE: design/ridf_pkg.sv
// Package for the recent-identifier duplicate filter.
// Holds field widths, item kind codes and the sequencer state type.
`timescale 1ns / 1ps
package ridf_pkg;
  localparam int unsigned IdWidth  = 64;
  localparam int unsigned CfgWidth = 7;

  typedef enum logic [0:0] {
    KIND_ADD    = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;
endpackage

FILE: design/ridf_if.sv
// Valid/ready channel interfaces for the duplicate filter.
// Depends on ridf_pkg for field widths.
`timescale 1ns / 1ps
interface ridf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ridf_pkg::IdWidth-1:0]  session_number;
  modport source (output valid, kind, session_number, input ready);
  modport sink   (input valid, kind, session_number, output ready);
endinterface

interface ridf_out_if;
  logic valid;
  logic ready;
  logic was_present;
  logic accepted;
  modport source (output valid, was_present, accepted, input ready);
  modport sink   (input valid, was_present, accepted, output ready);
endinterface

interface ridf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ridf_pkg::CfgWidth-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: design/ridf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ridf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] wr_addr,
  input  logic [Width-1:0]                 wr_data,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] rd_addr,
  output logic [Width-1:0]                 rd_data
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: design/recent_id_duplicate_filter.sv
// Rate: an item is accepted, scanned against the n remembered identifiers
// (0 up to the window) one entry per cycle through the single read port of
// the history RAM, then resolved. The next item is accepted only after the
// previous one has left the done state.
// Results sit in an output register, so the next item starts while an
// earlier result waits. A finished item holds in the done state, and the
// input stalls, while that register is still full. Writing the window
// register clears the history at once (fill count reset) and takes effect
// on the next item.
// Depends on ridf_pkg, ridf_if and ridf_ram.
`timescale 1ns / 1ps
module recent_id_duplicate_filter #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input logic      clk,
  input logic      rst,
  ridf_cfg_if.sink cfg,
  ridf_in_if.sink  in_ch,
  ridf_out_if.source out_ch
);
  localparam int unsigned AW = $clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

  ridf_pkg::state_t state, state_next;

  logic [ridf_pkg::CfgWidth-1:0] window_count;
  logic [CW-1:0] eff_win;
  logic [AW-1:0] write_slot;
  logic          window_filled;
  logic          item_kind;
  logic [ridf_pkg::IdWidth-1:0] item_id;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] valid_cnt;
  logic          rd_pend;
  logic          hit;
  logic [ridf_pkg::IdWidth-1:0] rd_data;
  logic          wr_en;
  logic          take_in;
  logic          out_free;

  // Clamp the window to [1, depth]
  always_comb begin
    if (window_count == '0) begin
      eff_win = CW'(1);
    end else if (32'(window_count) > HISTORY_DEPTH) begin
      eff_win = CW'(HISTORY_DEPTH);
    end else begin
      eff_win = CW'(window_count);
    end
  end

  assign valid_cnt = window_filled ? eff_win : CW'(write_slot);
  assign cfg.ready = (state == ridf_pkg::ST_IDLE);
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign take_in   = in_ch.valid && in_ch.ready;
  assign wr_en     = (state == ridf_pkg::ST_DONE) && out_free && !hit &&
                     (item_kind == ridf_pkg::KIND_ADD);

  ridf_ram #(.Width(ridf_pkg::IdWidth), .Depth(HISTORY_DEPTH)) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_slot),
    .wr_data (item_id),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ridf_pkg::ST_IDLE: if (take_in) state_next = ridf_pkg::ST_SCAN;
      ridf_pkg::ST_SCAN: if (scan_idx >= valid_cnt && !rd_pend)
        state_next = ridf_pkg::ST_DONE;
      ridf_pkg::ST_DONE: if (out_free) state_next = ridf_pkg::ST_IDLE;
      default: state_next = ridf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ch.ready = (state == ridf_pkg::ST_IDLE) && !cfg.valid;
  end

  // Sequencer, scan and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ridf_pkg::ST_IDLE;
      window_count  <= ridf_pkg::CfgWidth'(64);
      write_slot    <= '0;
      window_filled <= 1'b0;
      out_ch.valid  <= 1'b0;
      rd_pend       <= 1'b0;
      scan_idx      <= '0;
      hit           <= 1'b0;
    end else begin
      state <= state_next;
      // Load the output register from the done state, drop it on handoff
      if (state == ridf_pkg::ST_DONE && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        window_count  <= cfg.data;
        write_slot    <= '0;
        window_filled <= 1'b0;
      end
      case (state)
        ridf_pkg::ST_IDLE: begin
          scan_idx <= '0;
          rd_pend  <= 1'b0;
          hit      <= 1'b0;
        end
        ridf_pkg::ST_SCAN: begin
          // Issue one read a cycle, compare the data of the last one
          if (rd_pend && rd_data == item_id) hit <= 1'b1;
          if (scan_idx < valid_cnt) begin
            scan_idx <= scan_idx + CW'(1);
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
        end
        ridf_pkg::ST_DONE: begin
          if (out_free) begin
            out_ch.was_present <= hit;
            out_ch.accepted    <= wr_en;
            if (wr_en) begin
              if (CW'(write_slot) + CW'(1) >= eff_win) begin
                write_slot    <= '0;
                window_filled <= 1'b1;
              end else begin
                write_slot <= write_slot + AW'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (take_in) begin
      item_kind <= in_ch.kind;
      item_id   <= in_ch.session_number;
    end
  end

  a_no_store_on_lookup: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> item_kind == ridf_pkg::KIND_ADD && !hit)
    else $error("store on lookup or duplicate");
  a_accept_not_dup: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.accepted && out_ch.was_present))
    else $error("accepted duplicate");
  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    CW'(write_slot) < eff_win || window_filled == 1'b0)
    else $error("write slot beyond window");
endmodule
